FILE: sv/vbe_pkg.sv
// ----------------------------------------------------------------------------
// vbe_pkg
// Shared constants, register codes and transaction types of the value binning
// one-hot encoder.
// ----------------------------------------------------------------------------
package vbe_pkg;

    localparam int MAX_BINS     = 64;
    localparam int MAX_FEATURES = 64;
    localparam int VALUE_BITS   = 16;

    localparam int BIN_W    = 6;
    localparam int FEAT_W   = 6;
    localparam int CNT_W    = 7;
    localparam int SCALE_W  = 24;
    localparam int WEIGHT_W = 16;
    localparam int DIFF_W   = VALUE_BITS + 1;
    localparam int PROD_W   = DIFF_W + SCALE_W + 1;
    localparam int POS_FRAC = 24;
    localparam int POS_W    = PROD_W - POS_FRAC;
    localparam int ALPHA_W  = 15;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [WEIGHT_W-1:0] ONE_Q15 = WEIGHT_W'(32768);

    localparam logic [CNT_W-1:0]      BIN_COUNT_RST     = CNT_W'(16);
    localparam logic [CNT_W-1:0]      FEATURE_COUNT_RST = CNT_W'(1);
    localparam logic [VALUE_BITS-1:0] RANGE_LOW_RST     = '0;
    localparam logic [SCALE_W-1:0]    BIN_SCALE_RST     = SCALE_W'(65536);

    typedef enum logic [2:0] {
        REG_BIN_COUNT     = 3'd0,
        REG_FEATURE_COUNT = 3'd1,
        REG_RANGE_LOW     = 3'd2,
        REG_BIN_SCALE     = 3'd3,
        REG_SOFT_MODE     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0]             bin_count;
        logic [CNT_W-1:0]             feature_count;
        logic signed [VALUE_BITS-1:0] range_low;
        logic [SCALE_W-1:0]           bin_scale;
        logic                         soft_mode;
    } cfg_t;

    // Per-feature bookkeeping carried along the front pipeline.
    typedef struct packed {
        logic [FEAT_W-1:0] fidx;
        logic              lastf;
        logic [BIN_W-1:0]  n_last;
        logic              soft_sel;
    } meta_t;

    // One classified feature: bin a gets a_w, bin a+1 gets b_w, others zero.
    typedef struct packed {
        logic [BIN_W-1:0]    a_bin;
        logic [WEIGHT_W-1:0] a_w;
        logic [WEIGHT_W-1:0] b_w;
        logic [BIN_W-1:0]    n_last;
        logic [FEAT_W-1:0]   fidx;
        logic                lastf;
    } desc_t;

endpackage

FILE: sv/vbe_cfg.sv
// ----------------------------------------------------------------------------
// vbe_cfg
// APB register file holding the binning configuration.
// ----------------------------------------------------------------------------
module vbe_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vbe_pkg::ADDR_W-1:0] paddr,
    input  logic [vbe_pkg::DATA_W-1:0] pwdata,
    output logic [vbe_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output vbe_pkg::cfg_t              cfg
);

    logic [vbe_pkg::CNT_W-1:0]      bin_count_reg,     bin_count_next;
    logic [vbe_pkg::CNT_W-1:0]      feature_count_reg, feature_count_next;
    logic [vbe_pkg::VALUE_BITS-1:0] range_low_reg,     range_low_next;
    logic [vbe_pkg::SCALE_W-1:0]    bin_scale_reg,     bin_scale_next;
    logic                           soft_mode_reg,     soft_mode_next;
    logic                           wr_en;
    vbe_pkg::reg_idx_t              idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = vbe_pkg::reg_idx_t'(paddr[vbe_pkg::ADDR_W-1:2]);

    always_comb
    begin
        bin_count_next     = bin_count_reg;
        feature_count_next = feature_count_reg;
        range_low_next     = range_low_reg;
        bin_scale_next     = bin_scale_reg;
        soft_mode_next     = soft_mode_reg;
        if (wr_en)
        begin
            case (idx)
                vbe_pkg::REG_BIN_COUNT:
                    bin_count_next = pwdata[vbe_pkg::CNT_W-1:0];
                vbe_pkg::REG_FEATURE_COUNT:
                    feature_count_next = pwdata[vbe_pkg::CNT_W-1:0];
                vbe_pkg::REG_RANGE_LOW:
                    range_low_next = pwdata[vbe_pkg::VALUE_BITS-1:0];
                vbe_pkg::REG_BIN_SCALE:
                    bin_scale_next = pwdata[vbe_pkg::SCALE_W-1:0];
                vbe_pkg::REG_SOFT_MODE:
                    soft_mode_next = pwdata[0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg     <= vbe_pkg::BIN_COUNT_RST;
            feature_count_reg <= vbe_pkg::FEATURE_COUNT_RST;
            range_low_reg     <= vbe_pkg::RANGE_LOW_RST;
            bin_scale_reg     <= vbe_pkg::BIN_SCALE_RST;
            soft_mode_reg     <= 1'b0;
        end
        else
        begin
            bin_count_reg     <= bin_count_next;
            feature_count_reg <= feature_count_next;
            range_low_reg     <= range_low_next;
            bin_scale_reg     <= bin_scale_next;
            soft_mode_reg     <= soft_mode_next;
        end
    end

    always_comb
    begin
        case (idx)
            vbe_pkg::REG_BIN_COUNT:
                prdata = vbe_pkg::DATA_W'(bin_count_reg);
            vbe_pkg::REG_FEATURE_COUNT:
                prdata = vbe_pkg::DATA_W'(feature_count_reg);
            vbe_pkg::REG_RANGE_LOW:
                prdata = vbe_pkg::DATA_W'(range_low_reg);
            vbe_pkg::REG_BIN_SCALE:
                prdata = vbe_pkg::DATA_W'(bin_scale_reg);
            vbe_pkg::REG_SOFT_MODE:
                prdata = vbe_pkg::DATA_W'(soft_mode_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.bin_count     = bin_count_reg;
    assign cfg.feature_count = feature_count_reg;
    assign cfg.range_low     = $signed(range_low_reg);
    assign cfg.bin_scale     = bin_scale_reg;
    assign cfg.soft_mode     = soft_mode_reg;

endmodule

FILE: sv/vbe_front.sv
// ----------------------------------------------------------------------------
// vbe_front
// Accepts feature samples, scales them to a bin position and classifies the
// position into at most two weighted bins.
// ----------------------------------------------------------------------------
module vbe_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  vbe_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [vbe_pkg::VALUE_BITS-1:0] in_value,
    output logic                           push,
    output vbe_pkg::desc_t                 push_desc,
    input  logic                           queue_full
);

    localparam int LO_PAD = vbe_pkg::POS_W - vbe_pkg::BIN_W;

    logic                                 a_valid_reg, a_valid_next;
    logic                                 b_valid_reg, b_valid_next;
    logic [vbe_pkg::FEAT_W-1:0]           counter_reg, counter_next;
    logic signed [vbe_pkg::DIFF_W-1:0]    d_reg;
    vbe_pkg::meta_t                       a_meta_reg;
    logic signed [vbe_pkg::PROD_W-1:0]    p_reg;
    vbe_pkg::meta_t                       b_meta_reg;

    logic                                 accept;
    logic                                 a_en;
    logic                                 b_en;
    logic [vbe_pkg::CNT_W-1:0]            n_clamped;
    logic [vbe_pkg::CNT_W-1:0]            fc_clamped;
    logic                                 lastf;
    logic signed [vbe_pkg::DIFF_W-1:0]    diff;
    logic signed [vbe_pkg::PROD_W-1:0]    prod;
    logic signed [vbe_pkg::PROD_W-1:0]    q;
    logic signed [vbe_pkg::POS_W-1:0]     fl;
    logic signed [vbe_pkg::POS_W-1:0]     lo;
    logic signed [vbe_pkg::POS_W-1:0]     top_bin;
    logic [vbe_pkg::ALPHA_W-1:0]          alpha;

    // Stage B moves into the queue whenever there is room; stage A follows.
    assign b_en     = !b_valid_reg || !queue_full;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;
    assign accept   = in_valid & a_en;
    assign push     = b_valid_reg & !queue_full;

    always_comb
    begin
        if (cfg.bin_count < vbe_pkg::CNT_W'(2))
            n_clamped = vbe_pkg::CNT_W'(2);
        else if (cfg.bin_count > vbe_pkg::CNT_W'(vbe_pkg::MAX_BINS))
            n_clamped = vbe_pkg::CNT_W'(vbe_pkg::MAX_BINS);
        else
            n_clamped = cfg.bin_count;

        if (cfg.feature_count == '0)
            fc_clamped = vbe_pkg::CNT_W'(1);
        else if (cfg.feature_count > vbe_pkg::CNT_W'(vbe_pkg::MAX_FEATURES))
            fc_clamped = vbe_pkg::CNT_W'(vbe_pkg::MAX_FEATURES);
        else
            fc_clamped = cfg.feature_count;
    end

    assign lastf = (vbe_pkg::CNT_W'(counter_reg) + vbe_pkg::CNT_W'(1)) >= fc_clamped;
    assign diff  = vbe_pkg::DIFF_W'(signed'(in_value)) - vbe_pkg::DIFF_W'(cfg.range_low);
    assign prod  = d_reg * $signed({1'b0, cfg.bin_scale});

    always_comb
    begin
        a_valid_next = a_en ? in_valid : a_valid_reg;
        b_valid_next = b_en ? a_valid_reg : b_valid_reg;
        counter_next = counter_reg;
        if (accept)
            counter_next = lastf ? '0 : counter_reg + vbe_pkg::FEAT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            counter_reg <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg               <= diff;
            a_meta_reg.fidx     <= counter_reg;
            a_meta_reg.lastf    <= lastf;
            a_meta_reg.n_last   <= vbe_pkg::BIN_W'(n_clamped - vbe_pkg::CNT_W'(1));
            a_meta_reg.soft_sel <= cfg.soft_mode;
        end
        if (b_en && a_valid_reg)
        begin
            p_reg      <= prod;
            b_meta_reg <= a_meta_reg;
        end
    end

    // The integer part of the position is its upper bits taken as signed,
    // which is the floor. Soft mode first moves the position down half a bin.
    assign q       = p_reg - (vbe_pkg::PROD_W'(1) <<< (vbe_pkg::POS_FRAC - 1));
    assign fl      = p_reg[vbe_pkg::PROD_W-1:vbe_pkg::POS_FRAC];
    assign lo      = q[vbe_pkg::PROD_W-1:vbe_pkg::POS_FRAC];
    assign alpha   = q[vbe_pkg::POS_FRAC-1 -: vbe_pkg::ALPHA_W];
    assign top_bin = $signed({{LO_PAD{1'b0}}, b_meta_reg.n_last});

    always_comb
    begin
        push_desc.n_last = b_meta_reg.n_last;
        push_desc.fidx   = b_meta_reg.fidx;
        push_desc.lastf  = b_meta_reg.lastf;
        push_desc.a_w    = vbe_pkg::ONE_Q15;
        push_desc.b_w    = '0;
        if (!b_meta_reg.soft_sel)
        begin
            if (fl < 0)
                push_desc.a_bin = '0;
            else if (fl > top_bin)
                push_desc.a_bin = b_meta_reg.n_last;
            else
                push_desc.a_bin = fl[vbe_pkg::BIN_W-1:0];
        end
        else
        begin
            // Below the first bin center bin 0 takes all; at or past the last
            // center the top bin takes all.
            if (lo < 0)
                push_desc.a_bin = '0;
            else if (lo >= top_bin)
                push_desc.a_bin = b_meta_reg.n_last;
            else
            begin
                push_desc.a_bin = lo[vbe_pkg::BIN_W-1:0];
                push_desc.a_w   = vbe_pkg::ONE_Q15 - vbe_pkg::WEIGHT_W'(alpha);
                push_desc.b_w   = vbe_pkg::WEIGHT_W'(alpha);
            end
        end
    end

endmodule

FILE: sv/vbe_queue.sv
// ----------------------------------------------------------------------------
// vbe_queue
// Small register FIFO of classified features between front and back end.
// ----------------------------------------------------------------------------
module vbe_queue #(
    parameter int DEPTH = vbe_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vbe_pkg::desc_t push_desc,
    output logic           full,
    input  logic           pop,
    output vbe_pkg::desc_t head,
    output logic           empty
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    vbe_pkg::desc_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0]   count_reg,  count_next;

    assign full  = count_reg == COUNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + COUNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

FILE: sv/vbe_back.sv
// ----------------------------------------------------------------------------
// vbe_back
// Sweeps the bins of the feature at the queue head and drives one weight
// transaction per bin through an output register.
// ----------------------------------------------------------------------------
module vbe_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vbe_pkg::desc_t                   head,
    input  logic                             empty,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [vbe_pkg::FEAT_W-1:0]       out_fidx,
    output logic [vbe_pkg::BIN_W-1:0]        out_bin,
    output logic [vbe_pkg::WEIGHT_W-1:0]     out_weight,
    output logic                             out_last_bin,
    output logic                             out_last_feature
);

    logic                          valid_reg, valid_next;
    logic [vbe_pkg::BIN_W-1:0]     k_reg,     k_next;
    logic [vbe_pkg::FEAT_W-1:0]    fidx_reg;
    logic [vbe_pkg::BIN_W-1:0]     bin_reg;
    logic [vbe_pkg::WEIGHT_W-1:0]  weight_reg;
    logic                          last_bin_reg;
    logic                          last_feature_reg;

    logic                          load;
    logic                          at_end;
    logic [vbe_pkg::WEIGHT_W-1:0]  weight;

    assign load   = !empty && (!valid_reg || out_ready);
    assign at_end = k_reg == head.n_last;
    assign pop    = load && at_end;

    always_comb
    begin
        if (k_reg == head.a_bin)
            weight = head.a_w;
        else if (k_reg == vbe_pkg::BIN_W'(head.a_bin + vbe_pkg::BIN_W'(1)))
            weight = head.b_w;
        else
            weight = '0;
    end

    always_comb
    begin
        valid_next = valid_reg;
        k_next     = k_reg;
        if (load)
        begin
            valid_next = 1'b1;
            k_next     = at_end ? '0 : k_reg + vbe_pkg::BIN_W'(1);
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fidx_reg         <= head.fidx;
            bin_reg          <= k_reg;
            weight_reg       <= weight;
            last_bin_reg     <= at_end;
            last_feature_reg <= head.lastf;
        end
    end

    assign out_valid        = valid_reg;
    assign out_fidx         = fidx_reg;
    assign out_bin          = bin_reg;
    assign out_weight       = weight_reg;
    assign out_last_bin     = last_bin_reg;
    assign out_last_feature = last_feature_reg;

endmodule

FILE: sv/value_binning_onehot_encoder.sv
// Path: a sample passes stage A, stage B, the queue and the back end output register.
// Throughput: one weight transaction per cycle while m_tready is high; a feature yields
// bin_count of them (clamped to 2 to 64). The back end sweeps the bins of a feature, one
// per accepted transaction; the front end keeps taking samples until the queue is full.
// Reset: rst_n puts the config registers, valid flags, pointers and feature counter
// to their reset values at once; data registers are not. s_tready is high after reset.
// ----------------------------------------------------------------------------
// value_binning_onehot_encoder
// Uniform binning of signed Q8.8 samples into hard one-hot or soft two-bin
// weights, one output transaction per bin.
// ----------------------------------------------------------------------------
module value_binning_onehot_encoder #(
    parameter int QUEUE_DEPTH = vbe_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vbe_pkg::ADDR_W-1:0] paddr,
    input  logic [vbe_pkg::DATA_W-1:0] pwdata,
    output logic [vbe_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // [15:0] feature_value
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // [5:0] feature_index, [11:6] bin_index,
                                                  // [27:12] weight, [31:28] zero
    output logic                       m_tlast,
    output logic [0:0]                 m_tuser    // [0] last_feature
);

    vbe_pkg::cfg_t                  cfg;
    logic                           push;
    vbe_pkg::desc_t                 push_desc;
    logic                           queue_full;
    logic                           pop;
    vbe_pkg::desc_t                 head;
    logic                           queue_empty;
    logic [vbe_pkg::FEAT_W-1:0]     out_fidx;
    logic [vbe_pkg::BIN_W-1:0]      out_bin;
    logic [vbe_pkg::WEIGHT_W-1:0]   out_weight;
    logic                           out_last_feature;

    vbe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_value   (s_tdata[vbe_pkg::VALUE_BITS-1:0]),
        .push       (push),
        .push_desc  (push_desc),
        .queue_full (queue_full)
    );

    vbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    vbe_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .empty            (queue_empty),
        .pop              (pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_fidx         (out_fidx),
        .out_bin          (out_bin),
        .out_weight       (out_weight),
        .out_last_bin     (m_tlast),
        .out_last_feature (out_last_feature)
    );

    assign m_tdata = {4'b0000, out_weight, out_bin, out_fidx};
    assign m_tuser = out_last_feature;

endmodule
